@@ src/sbhs_pkg.sv @@
package sbhs_pkg;

    localparam int MAX_TX      = 7;
    localparam int TX_CNT_W    = $clog2(MAX_TX + 1);
    localparam int TX_IDX_W    = $clog2(MAX_TX);
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  command;
        logic [31:0] address;
        logic [7:0]  length_minus_one;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [2:0] status;
        logic [1:0] wants;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [MAX_TX-1:0][7:0] tx_bytes;
        logic [TX_CNT_W-1:0]    tx_count;
        logic                   tx_valid;
        logic [7:0]             read_byte;
        logic                   read_valid;
        logic [2:0]             status;
        logic [1:0]             wants;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ src/sbhs_front.sv @@
module sbhs_front
    import sbhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    item,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output job_t        job
);

    localparam logic [1:0] OP_COMMAND  = 2'd0;
    localparam logic [1:0] OP_PAYLOAD  = 2'd1;
    localparam logic [1:0] OP_RECEIVED = 2'd2;

    localparam logic [2:0] CMD_SYNC      = 3'd0;
    localparam logic [2:0] CMD_GET       = 3'd1;
    localparam logic [2:0] CMD_VERSION   = 3'd2;
    localparam logic [2:0] CMD_ID        = 3'd3;
    localparam logic [2:0] CMD_WRITE     = 3'd4;
    localparam logic [2:0] CMD_ERASE     = 3'd5;
    localparam logic [2:0] CMD_UNPROTECT = 3'd6;
    localparam logic [2:0] CMD_INVALID   = 3'd7;

    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_NACK       = 3'd2;
    localparam logic [2:0] ST_TIMEOUT    = 3'd3;
    localparam logic [2:0] ST_UNEXPECTED = 3'd4;

    localparam logic [7:0] BYTE_SYNC  = 8'h5A;
    localparam logic [7:0] BYTE_ACK   = 8'h79;
    localparam logic [7:0] BYTE_NACK  = 8'h1F;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] CODE_GET   = 8'h00;
    localparam logic [7:0] CODE_VER   = 8'h01;
    localparam logic [7:0] CODE_ID    = 8'h02;
    localparam logic [7:0] CODE_WRITE = 8'h31;
    localparam logic [7:0] CODE_ERASE = 8'h44;
    localparam logic [7:0] CODE_UNPR  = 8'h73;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ACK_CMD,
        PH_READ,
        PH_ACK_ADDR,
        PH_PAYLOAD,
        PH_ACK_FINAL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  active_cmd_reg, active_cmd_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  checksum_reg, checksum_next;
    logic [15:0] poll_count_reg, poll_count_next;
    logic [31:0] target_addr_reg, target_addr_next;
    logic [15:0] poll_limit_reg;

    logic [1:0]  expect_op;
    logic [7:0]  code;
    logic [7:0]  addr_cs;
    logic [7:0]  pay_cs;
    logic [15:0] poll_inc;
    logic        is_ack;
    logic        is_nack;

    function automatic logic [1:0] wants_of(phase_t p);
        logic [1:0] w;
        if (p == PH_IDLE)
            w = OP_COMMAND;
        else if (p == PH_PAYLOAD)
            w = OP_PAYLOAD;
        else
            w = OP_RECEIVED;
        return w;
    endfunction

    function automatic logic [7:0] cmd_code(logic [2:0] c);
        logic [7:0] v;
        unique case (c)
            CMD_GET:       v = CODE_GET;
            CMD_VERSION:   v = CODE_VER;
            CMD_ID:        v = CODE_ID;
            CMD_WRITE:     v = CODE_WRITE;
            CMD_ERASE:     v = CODE_ERASE;
            CMD_UNPROTECT: v = CODE_UNPR;
            default:       v = BYTE_ZERO;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] reply_len(logic [2:0] c);
        logic [8:0] v;
        unique case (c)
            CMD_GET:     v = 9'd14;
            CMD_VERSION: v = 9'd3;
            CMD_ID:      v = 9'd5;
            default:     v = 9'd0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        expect_op = wants_of(phase_reg);
        code      = cmd_code(item.command);
        addr_cs   = target_addr_reg[31:24] ^ target_addr_reg[23:16]
                  ^ target_addr_reg[15:8] ^ target_addr_reg[7:0];
        pay_cs    = checksum_reg ^ item.data_byte;
        poll_inc  = poll_count_reg + 16'd1;
        is_ack    = (item.data_byte == BYTE_ACK);
        is_nack   = (item.data_byte == BYTE_NACK);

        phase_next       = phase_reg;
        active_cmd_next  = active_cmd_reg;
        bytes_left_next  = bytes_left_reg;
        checksum_next    = checksum_reg;
        poll_count_next  = poll_count_reg;
        target_addr_next = target_addr_reg;

        job            = '0;
        job.tx_count   = TX_CNT_W'(1);
        job.status     = ST_BUSY;

        if (item.opcode != expect_op) begin
            job.status = ST_UNEXPECTED;
        end else begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                    if (item.command == CMD_INVALID) begin
                        job.status = ST_UNEXPECTED;
                    end else begin
                        active_cmd_next = item.command;
                        job.tx_valid    = 1'b1;
                        job.tx_bytes[0] = BYTE_SYNC;
                        if (item.command == CMD_SYNC) begin
                            job.tx_bytes[1] = BYTE_ZERO;
                            job.tx_count    = TX_CNT_W'(2);
                        end else begin
                            job.tx_bytes[1] = code;
                            job.tx_bytes[2] = ~code;
                            job.tx_bytes[3] = BYTE_ZERO;
                            job.tx_count    = TX_CNT_W'(4);
                        end
                        if (item.command == CMD_WRITE) begin
                            bytes_left_next  = {1'b0, item.length_minus_one} + 9'd1;
                            target_addr_next = item.address;
                        end
                        poll_count_next = '0;
                        phase_next      = PH_ACK_CMD;
                    end
                end
                PH_ACK_CMD, PH_ACK_ADDR, PH_ACK_FINAL:
                begin
                    if (is_ack) begin
                        job.tx_valid    = 1'b1;
                        job.tx_bytes[0] = BYTE_ACK;
                        if (phase_reg == PH_ACK_CMD) begin
                            case (active_cmd_reg) inside
                                CMD_GET, CMD_VERSION, CMD_ID:
                                begin
                                    bytes_left_next = reply_len(active_cmd_reg);
                                    phase_next      = PH_READ;
                                end
                                CMD_WRITE:
                                begin
                                    job.tx_bytes[1] = target_addr_reg[31:24];
                                    job.tx_bytes[2] = target_addr_reg[23:16];
                                    job.tx_bytes[3] = target_addr_reg[15:8];
                                    job.tx_bytes[4] = target_addr_reg[7:0];
                                    job.tx_bytes[5] = addr_cs;
                                    job.tx_bytes[6] = BYTE_ZERO;
                                    job.tx_count    = TX_CNT_W'(7);
                                    poll_count_next = '0;
                                    phase_next      = PH_ACK_ADDR;
                                end
                                CMD_ERASE:
                                begin
                                    job.tx_bytes[1] = BYTE_ONES;
                                    job.tx_bytes[2] = BYTE_ONES;
                                    job.tx_bytes[3] = BYTE_ZERO;
                                    job.tx_bytes[4] = BYTE_ZERO;
                                    job.tx_count    = TX_CNT_W'(5);
                                    poll_count_next = '0;
                                    phase_next      = PH_ACK_FINAL;
                                end
                                CMD_UNPROTECT:
                                begin
                                    job.tx_bytes[1] = BYTE_ZERO;
                                    job.tx_count    = TX_CNT_W'(2);
                                    poll_count_next = '0;
                                    phase_next      = PH_ACK_FINAL;
                                end
                                default:
                                begin
                                    job.status = ST_OK;
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end else if (phase_reg == PH_ACK_ADDR) begin
                            job.tx_bytes[1] = bytes_left_reg[7:0] - 8'd1;
                            job.tx_count    = TX_CNT_W'(2);
                            checksum_next   = bytes_left_reg[7:0] - 8'd1;
                            phase_next      = PH_PAYLOAD;
                        end else begin
                            job.status = ST_OK;
                            phase_next = PH_IDLE;
                        end
                    end else if (is_nack) begin
                        job.tx_valid    = 1'b1;
                        job.tx_bytes[0] = BYTE_ACK;
                        job.status      = ST_NACK;
                        phase_next      = PH_IDLE;
                    end else begin
                        poll_count_next = poll_inc;
                        if (poll_inc >= poll_limit_reg) begin
                            job.status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_READ:
                begin
                    job.read_valid = 1'b1;
                    job.read_byte  = item.data_byte;
                    if (bytes_left_reg <= 9'd1) begin
                        job.tx_valid    = 1'b1;
                        job.tx_bytes[0] = BYTE_ZERO;
                        bytes_left_next = '0;
                        poll_count_next = '0;
                        phase_next      = PH_ACK_FINAL;
                    end else begin
                        bytes_left_next = bytes_left_reg - 9'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    checksum_next   = pay_cs;
                    job.tx_valid    = 1'b1;
                    job.tx_bytes[0] = item.data_byte;
                    if (bytes_left_reg <= 9'd1) begin
                        job.tx_bytes[1] = pay_cs;
                        job.tx_bytes[2] = BYTE_ZERO;
                        job.tx_count    = TX_CNT_W'(3);
                        bytes_left_next = '0;
                        poll_count_next = '0;
                        phase_next      = PH_ACK_FINAL;
                    end else begin
                        bytes_left_next = bytes_left_reg - 9'd1;
                    end
                end
                default:
                begin
                    job.status = ST_UNEXPECTED;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        job.wants = wants_of(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            active_cmd_reg  <= '0;
            bytes_left_reg  <= '0;
            checksum_reg    <= '0;
            poll_count_reg  <= '0;
            target_addr_reg <= '0;
            poll_limit_reg  <= POLL_LIMIT_RESET;
        end else begin
            if (cfg_wr_en)
                poll_limit_reg <= cfg_wr_data;
            if (accept) begin
                phase_reg       <= phase_next;
                active_cmd_reg  <= active_cmd_next;
                bytes_left_reg  <= bytes_left_next;
                checksum_reg    <= checksum_next;
                poll_count_reg  <= poll_count_next;
                target_addr_reg <= target_addr_next;
            end
        end
    end

endmodule

@@ src/sbhs_queue.sv @@
module sbhs_queue
    import sbhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        head,
    output queue_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

    always_comb
    begin
        stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty  = (count_reg == '0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
        head = slots[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !stat.full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push lost");

endmodule

@@ src/sbhs_back.sv @@
module sbhs_back
    import sbhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  queue_stat_t qstat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    logic [TX_IDX_W-1:0] idx_reg, idx_next;
    logic                valid_reg, valid_next;
    out_item_t           data_reg, data_next;
    logic                load;
    logic                at_last;

    always_comb
    begin
        load    = !qstat.empty && (!valid_reg || out_ready);
        at_last = (TX_CNT_W'(idx_reg) == (head.tx_count - TX_CNT_W'(1)));
        pop     = load && at_last;

        valid_next = valid_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next          = 1'b1;
            data_next.tx_byte   = head.tx_bytes[idx_reg];
            data_next.tx_valid  = head.tx_valid;
            data_next.read_byte = head.read_byte;
            data_next.read_valid = head.read_valid;
            data_next.status    = head.status;
            data_next.wants     = head.wants;
            data_next.last      = at_last;
            idx_next            = at_last ? '0 : idx_reg + TX_IDX_W'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && data_reg.last))
        else $error("job retired without last flag");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (TX_CNT_W'(idx_reg) < head.tx_count))
        else $error("byte index past job length");

endmodule

@@ src/spi_bootloader_host_sequencer.sv @@
// Each accepted item becomes one job in a two-entry queue; the job is written into a
// queue slot, and the result register loads from the queue head once it is free.
// The back end emits one result per cycle while out_ready is high; an item has n
// results (1 to 7). With out_ready high, one-result items sustain one transfer per cycle.
// Reset (rst_n low, asynchronous) returns to idle, empties the queue and sets the
// acknowledge poll limit to 1000.
module spi_bootloader_host_sequencer
    import sbhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    job_t        new_job;
    job_t        head_job;
    queue_stat_t qstat;
    logic        in_accept;
    logic        pop;

    assign in_ready  = !qstat.full;
    assign in_accept = in_valid && in_ready;

    sbhs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .item        (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job         (new_job)
    );

    sbhs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .push_job (new_job),
        .pop      (pop),
        .head     (head_job),
        .stat     (qstat)
    );

    sbhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_job),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
